@@ rtl/core/nsr_pkg.sv @@
// Shared types and constants of the NMEA sentence receiver.
// No dependencies; nsr_front, nsr_queue, nsr_back, nsr_emit and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package nsr_pkg;

    localparam int unsigned MaxSentence = 128;
    localparam logic [15:0] ClearTimeoutReset = 16'd2000;
    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueueAw = $clog2(QueueDepth);

    localparam logic [1:0] STATUS_GOOD  = 2'd0;
    localparam logic [1:0] STATUS_BAD   = 2'd1;
    localparam logic [1:0] STATUS_CLEAR = 2'd2;

    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_GGA   = 2'd1;
    localparam logic [1:0] KIND_RMC   = 2'd2;
    localparam logic [1:0] KIND_GLL   = 2'd3;

    typedef enum logic [2:0] {
        CLS_OTHER,
        CLS_DOLLAR,
        CLS_CR,
        CLS_STAR,
        CLS_COMMA,
        CLS_DOT
    } nsr_cls_t;

    typedef struct packed {
        logic       action;
        logic [7:0] data;
        nsr_cls_t   cls;
        logic [3:0] dec;
        logic [3:0] hex;
    } nsr_item_t;

    // ddmm.mmmm kept as degrees, minute digits and fraction
    typedef struct packed {
        logic [9:0]  deg;
        logic [3:0]  min_tens;
        logic [3:0]  min_ones;
        logic [13:0] frac;
    } nsr_pos_t;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] kind;
        logic       fix;
        nsr_pos_t   lat;
        logic       south;
        nsr_pos_t   lon;
        logic       west;
        logic [6:0] sats;
    } nsr_raw_t;

endpackage

`default_nettype wire

@@ rtl/core/nsr_if.sv @@
// Channel interfaces of the NMEA sentence receiver: input words, results, config.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface nsr_rx_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] byte_in;
    modport source (output valid, action, byte_in, input ready);
    modport sink   (input valid, action, byte_in, output ready);
endinterface

interface nsr_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [1:0]         kind;
    logic               fix_valid;
    logic signed [27:0] latitude;
    logic signed [27:0] longitude;
    logic [6:0]         satellites;
    modport source (output valid, status, kind, fix_valid, latitude, longitude, satellites,
                    input ready);
    modport sink   (input valid, status, kind, fix_valid, latitude, longitude, satellites,
                    output ready);
endinterface

interface nsr_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] clear_timeout;
    modport source (output valid, clear_timeout, input ready);
    modport sink   (input valid, clear_timeout, output ready);
endinterface

`default_nettype wire

@@ rtl/core/nsr_front.sv @@
// Front end: accepts input words and classifies each character.
// Depends on nsr_pkg and nsr_if.
`timescale 1ns / 1ps
`default_nettype none

module nsr_front (
    nsr_rx_if.sink                rx,
    input  logic                  q_ready,
    output logic                  push,
    output nsr_pkg::nsr_item_t    item
);
    import nsr_pkg::*;

    logic [7:0] b;

    assign b        = rx.byte_in;
    assign rx.ready = q_ready;
    assign push     = rx.valid && q_ready;

    always_comb
    begin
        item.action = rx.action;
        item.data   = b;
        unique case (b)
            8'h24:   item.cls = CLS_DOLLAR;
            8'h0D:   item.cls = CLS_CR;
            8'h2A:   item.cls = CLS_STAR;
            8'h2C:   item.cls = CLS_COMMA;
            8'h2E:   item.cls = CLS_DOT;
            default: item.cls = CLS_OTHER;
        endcase
        item.dec = 4'd0;
        item.hex = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            item.dec = 4'(b - 8'h30);
            item.hex = 4'(b - 8'h30);
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            item.hex = 4'(b - 8'h37);
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            item.hex = 4'(b - 8'h57);
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/nsr_queue.sv @@
// Short queue between front and back end.
// Depends on nsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nsr_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  nsr_pkg::nsr_item_t    item_in,
    output logic                  ready,
    output logic                  valid,
    output nsr_pkg::nsr_item_t    item_out,
    input  logic                  pop
);
    import nsr_pkg::*;

    nsr_item_t          mem [QueueDepth];
    logic [QueueAw-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QueueAw-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QueueAw:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign ready    = count_reg != (QueueAw+1)'(QueueDepth);
    assign valid    = count_reg != '0;
    assign item_out = mem[rd_ptr_reg];
    assign do_push  = push && ready;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/nsr_back.sv @@
// Back end: sentence state, checksum, field parsing and timeout.
// Depends on nsr_pkg and nsr_if.
`timescale 1ns / 1ps
`default_nettype none

module nsr_back (
    input  logic                  clk,
    input  logic                  rst_n,
    nsr_cfg_if.sink               cfg,
    input  logic                  q_valid,
    input  nsr_pkg::nsr_item_t    q_item,
    output logic                  pop,
    output logic                  raw_valid,
    output nsr_pkg::nsr_raw_t     raw,
    input  logic                  raw_take
);
    import nsr_pkg::*;

    localparam int unsigned FL_VALID = 0;
    localparam int unsigned FL_LAT   = 1;
    localparam int unsigned FL_LON   = 2;
    localparam int unsigned FL_SOUTH = 3;
    localparam int unsigned FL_WEST  = 4;
    localparam int unsigned FL_DOT   = 5;

    typedef enum logic [2:0] {
        ROLE_NONE,
        ROLE_STATUS,
        ROLE_LAT,
        ROLE_NS,
        ROLE_LON,
        ROLE_EW,
        ROLE_SATS
    } role_t;

    typedef struct packed {
        logic [7:0]  rxor;
        logic        star;
        logic [7:0]  fxor;
        logic [3:0]  hex_prev2;
        logic [3:0]  hex_prev;
        logic        prev_comma;
        logic [7:0]  pos;
        logic [4:0]  comma;
        logic [23:0] type_chars;
        nsr_pos_t    lat;
        nsr_pos_t    lon;
        logic [2:0]  frac_digits;
        logic [5:0]  flags;
        logic [6:0]  sat;
    } sent_t;

    function automatic logic [1:0] kind_of(input logic [23:0] t);
        logic [1:0] k;
        k = KIND_OTHER;
        if (t == 24'h474741) k = KIND_GGA;
        if (t == 24'h524D43) k = KIND_RMC;
        if (t == 24'h474C4C) k = KIND_GLL;
        return k;
    endfunction

    function automatic role_t role_of(input logic [1:0] k, input logic [4:0] f);
        role_t r;
        r = ROLE_NONE;
        unique case (k)
            KIND_GGA:
            begin
                case (f)
                    5'd6:    r = ROLE_STATUS;
                    5'd2:    r = ROLE_LAT;
                    5'd3:    r = ROLE_NS;
                    5'd4:    r = ROLE_LON;
                    5'd5:    r = ROLE_EW;
                    5'd7:    r = ROLE_SATS;
                    default: r = ROLE_NONE;
                endcase
            end
            KIND_RMC:
            begin
                case (f)
                    5'd2:    r = ROLE_STATUS;
                    5'd3:    r = ROLE_LAT;
                    5'd4:    r = ROLE_NS;
                    5'd5:    r = ROLE_LON;
                    5'd6:    r = ROLE_EW;
                    default: r = ROLE_NONE;
                endcase
            end
            KIND_GLL:
            begin
                case (f)
                    5'd6:    r = ROLE_STATUS;
                    5'd1:    r = ROLE_LAT;
                    5'd2:    r = ROLE_NS;
                    5'd3:    r = ROLE_LON;
                    5'd4:    r = ROLE_EW;
                    default: r = ROLE_NONE;
                endcase
            end
            default: r = ROLE_NONE;
        endcase
        return r;
    endfunction

    function automatic nsr_pos_t int_digit(input nsr_pos_t p, input logic [3:0] d);
        nsr_pos_t q;
        q.frac = '0;
        if (p.deg >= 10'd100)
        begin
            q.deg      = 10'd999;
            q.min_tens = 4'd9;
            q.min_ones = 4'd9;
        end
        else
        begin
            q.deg      = 10'(p.deg * 10'd10 + 10'(p.min_tens));
            q.min_tens = p.min_tens;
            q.min_tens = p.min_ones;
            q.min_ones = d;
        end
        return q;
    endfunction

    function automatic logic [13:0] frac_add(input logic [13:0] fr, input logic [3:0] d,
                                             input logic [2:0] n);
        logic [13:0] s;
        case (n)
            3'd0:    s = 14'(d) * 14'd1000;
            3'd1:    s = 14'(d) * 14'd100;
            3'd2:    s = 14'(d) * 14'd10;
            default: s = 14'(d);
        endcase
        return fr + s;
    endfunction

    sent_t       s_reg, s_next;
    logic        in_sent_reg, in_sent_next;
    logic [15:0] tick_reg, tick_next;
    logic [15:0] timeout_reg, timeout_next;
    logic        raw_valid_reg, raw_valid_next;
    nsr_raw_t    raw_reg, raw_next;

    logic        produces;
    logic        raw_free;
    logic [1:0]  kind;
    role_t       role;
    logic        first;
    logic        good;
    logic [9:0]  sat_sum;
    nsr_item_t   it;

    assign it        = q_item;
    assign cfg.ready = 1'b1;
    assign raw_valid = raw_valid_reg;
    assign raw       = raw_reg;
    assign kind      = kind_of(s_reg.type_chars);
    assign role      = (s_reg.comma == '0) ? ROLE_NONE : role_of(kind, s_reg.comma);
    assign first     = s_reg.prev_comma;
    assign good      = {s_reg.hex_prev2, s_reg.hex_prev} == s_reg.fxor;
    assign sat_sum   = 10'(s_reg.sat) * 10'd10 + 10'(it.dec);
    assign raw_free  = !raw_valid_reg || raw_take;
    assign produces  = it.action ? (tick_reg >= timeout_reg)
                                 : (it.cls == CLS_CR && in_sent_reg);
    assign pop       = q_valid && (!produces || raw_free);

    always_comb
    begin
        s_next         = s_reg;
        in_sent_next   = in_sent_reg;
        tick_next      = tick_reg;
        timeout_next   = cfg.valid ? cfg.clear_timeout : timeout_reg;
        raw_valid_next = raw_valid_reg && !raw_take;
        raw_next       = raw_reg;

        if (pop)
        begin
            if (it.action)
            begin
                if (produces)
                begin
                    tick_next      = '0;
                    in_sent_next   = 1'b0;
                    s_next         = '0;
                    raw_next       = '0;
                    raw_next.status = STATUS_CLEAR;
                    raw_valid_next = 1'b1;
                end
                else
                begin
                    tick_next = tick_reg + 16'd1;
                end
            end
            else if (it.cls == CLS_DOLLAR)
            begin
                s_next       = '0;
                in_sent_next = 1'b1;
            end
            else if (!in_sent_reg)
            begin
                s_next = s_reg;
            end
            else if (it.cls == CLS_CR)
            begin
                raw_next        = '0;
                raw_next.status = good ? STATUS_GOOD : STATUS_BAD;
                raw_next.kind   = kind;
                raw_next.fix    = good && kind != KIND_OTHER && s_reg.flags[FL_VALID]
                                  && s_reg.flags[FL_LAT] && s_reg.flags[FL_LON];
                raw_next.lat    = s_reg.lat;
                raw_next.south  = s_reg.flags[FL_SOUTH];
                raw_next.lon    = s_reg.lon;
                raw_next.west   = s_reg.flags[FL_WEST];
                raw_next.sats   = (good && kind == KIND_GGA && s_reg.flags[FL_VALID])
                                  ? s_reg.sat : 7'd0;
                raw_valid_next  = 1'b1;
                in_sent_next    = 1'b0;
                tick_next       = '0;
                s_next          = '0;
            end
            else if (s_reg.pos >= 8'(MaxSentence))
            begin
                in_sent_next = 1'b0;
                s_next       = '0;
            end
            else
            begin
                if (!s_reg.star)
                begin
                    if (it.cls == CLS_STAR)
                    begin
                        s_next.star = 1'b1;
                        s_next.fxor = s_reg.rxor;
                    end
                    else
                    begin
                        s_next.rxor = s_reg.rxor ^ it.data;
                        if (it.cls == CLS_COMMA)
                        begin
                            if (s_reg.comma != 5'd31)
                            begin
                                s_next.comma = s_reg.comma + 5'd1;
                            end
                            s_next.frac_digits   = '0;
                            s_next.flags[FL_DOT] = 1'b0;
                        end
                        else
                        begin
                            case (role)
                                ROLE_STATUS:
                                begin
                                    if (first && ((kind == KIND_GGA) ? (it.data != 8'h30)
                                                                     : (it.data == 8'h41)))
                                    begin
                                        s_next.flags[FL_VALID] = 1'b1;
                                    end
                                end
                                ROLE_LAT, ROLE_LON:
                                begin
                                    if (role == ROLE_LAT)
                                    begin
                                        s_next.flags[FL_LAT] = 1'b1;
                                    end
                                    else
                                    begin
                                        s_next.flags[FL_LON] = 1'b1;
                                    end
                                    if (it.cls == CLS_DOT)
                                    begin
                                        s_next.flags[FL_DOT] = 1'b1;
                                    end
                                    else if (!s_reg.flags[FL_DOT])
                                    begin
                                        if (role == ROLE_LAT)
                                        begin
                                            s_next.lat = int_digit(s_reg.lat, it.dec);
                                        end
                                        else
                                        begin
                                            s_next.lon = int_digit(s_reg.lon, it.dec);
                                        end
                                    end
                                    else if (s_reg.frac_digits < 3'd4)
                                    begin
                                        if (role == ROLE_LAT)
                                        begin
                                            s_next.lat.frac = frac_add(s_reg.lat.frac, it.dec,
                                                                       s_reg.frac_digits);
                                        end
                                        else
                                        begin
                                            s_next.lon.frac = frac_add(s_reg.lon.frac, it.dec,
                                                                       s_reg.frac_digits);
                                        end
                                        s_next.frac_digits = s_reg.frac_digits + 3'd1;
                                    end
                                end
                                ROLE_NS:
                                begin
                                    if (first && it.data == 8'h53)
                                    begin
                                        s_next.flags[FL_SOUTH] = 1'b1;
                                    end
                                end
                                ROLE_EW:
                                begin
                                    if (first && it.data == 8'h57)
                                    begin
                                        s_next.flags[FL_WEST] = 1'b1;
                                    end
                                end
                                ROLE_SATS:
                                begin
                                    if (it.cls == CLS_DOT)
                                    begin
                                        s_next.flags[FL_DOT] = 1'b1;
                                    end
                                    else if (!s_reg.flags[FL_DOT])
                                    begin
                                        s_next.sat = (sat_sum > 10'd99) ? 7'd99 : 7'(sat_sum);
                                    end
                                end
                                default:
                                begin
                                    s_next.flags = s_reg.flags;
                                end
                            endcase
                        end
                    end
                end
                if (s_reg.pos >= 8'd2 && s_reg.pos <= 8'd4)
                begin
                    s_next.type_chars = {s_reg.type_chars[15:0], it.data};
                end
                s_next.hex_prev2  = s_reg.hex_prev;
                s_next.hex_prev   = it.hex;
                s_next.prev_comma = it.cls == CLS_COMMA;
                if (s_reg.pos != 8'd255)
                begin
                    s_next.pos = s_reg.pos + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg         <= '0;
            in_sent_reg   <= 1'b0;
            tick_reg      <= '0;
            timeout_reg   <= ClearTimeoutReset;
            raw_valid_reg <= 1'b0;
            raw_reg       <= '0;
        end
        else
        begin
            s_reg         <= s_next;
            in_sent_reg   <= in_sent_next;
            tick_reg      <= tick_next;
            timeout_reg   <= timeout_next;
            raw_valid_reg <= raw_valid_next;
            raw_reg       <= raw_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/nsr_emit.sv @@
// Result stage: converts positions to signed 1e-4 arc-minutes and holds the word.
// Depends on nsr_pkg and nsr_if.
`timescale 1ns / 1ps
`default_nettype none

module nsr_emit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  raw_valid,
    input  nsr_pkg::nsr_raw_t     raw,
    output logic                  raw_take,
    nsr_result_if.source          result
);
    import nsr_pkg::*;

    localparam logic [29:0] PosLimit = 30'd108000000;

    function automatic logic [27:0] conv(input nsr_pos_t p, input logic neg);
        logic [29:0] v;
        v = 30'(p.deg) * 30'd600000 + 30'(p.min_tens) * 30'd100000
          + 30'(p.min_ones) * 30'd10000 + 30'(p.frac);
        if (v > PosLimit)
        begin
            v = PosLimit;
        end
        return neg ? 28'(-v) : 28'(v);
    endfunction

    logic               valid_reg, valid_next;
    logic [1:0]         status_reg, status_next;
    logic [1:0]         kind_reg, kind_next;
    logic               fix_reg, fix_next;
    logic signed [27:0] lat_reg, lat_next;
    logic signed [27:0] lon_reg, lon_next;
    logic [6:0]         sats_reg, sats_next;
    logic               out_free;

    assign out_free = !valid_reg || result.ready;
    assign raw_take = raw_valid && out_free;

    assign result.valid      = valid_reg;
    assign result.status     = status_reg;
    assign result.kind       = kind_reg;
    assign result.fix_valid  = fix_reg;
    assign result.latitude   = lat_reg;
    assign result.longitude  = lon_reg;
    assign result.satellites = sats_reg;

    always_comb
    begin
        valid_next  = valid_reg && !result.ready;
        status_next = status_reg;
        kind_next   = kind_reg;
        fix_next    = fix_reg;
        lat_next    = lat_reg;
        lon_next    = lon_reg;
        sats_next   = sats_reg;
        if (raw_take)
        begin
            valid_next  = 1'b1;
            status_next = raw.status;
            kind_next   = raw.kind;
            fix_next    = raw.fix;
            lat_next    = raw.fix ? signed'(conv(raw.lat, raw.south)) : '0;
            lon_next    = raw.fix ? signed'(conv(raw.lon, raw.west)) : '0;
            sats_next   = raw.sats;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            status_reg <= '0;
            kind_reg   <= '0;
            fix_reg    <= 1'b0;
            lat_reg    <= '0;
            lon_reg    <= '0;
            sats_reg   <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            status_reg <= status_next;
            kind_reg   <= kind_next;
            fix_reg    <= fix_next;
            lat_reg    <= lat_next;
            lon_reg    <= lon_next;
            sats_reg   <= sats_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/nmea_sentence_receiver_unit.sv @@
// NMEA sentence receiver, top level.
// Depends on nsr_pkg, nsr_if, nsr_front, nsr_queue, nsr_back and nsr_emit.
//
// Channels: rx takes one word per handshake, either a received character
// (action 0, byte_in) or one timer tick (action 1). result gives one word per
// CR that ends a sentence (checksum status, sentence kind, fix flag, signed
// latitude and longitude in 1e-4 arc-minutes, GGA satellite count) and one
// clear word (status 2) when the tick count reaches clear_timeout. cfg writes
// clear_timeout; it is always ready and takes effect on the next word.
// Throughput: one rx word per cycle while result.ready stays high. A CR word
// passes through the four-entry queue, the sentence state update in the back
// end, then the position conversion into the output register.
// Reset: empty queue and output, hunting for '$', clear_timeout back to 2000.
// No clearing pass; the block takes words in the first cycle after reset.
// Stall: while result.ready is low the output word holds, one more result
// waits in the back end, and words without a result keep flowing until the
// queue fills; then rx.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module nmea_sentence_receiver_unit (
    input  logic         clk,
    input  logic         rst_n,
    nsr_rx_if.sink       rx,
    nsr_cfg_if.sink      cfg,
    nsr_result_if.source result
);
    import nsr_pkg::*;

    nsr_item_t front_item;
    nsr_item_t q_item;
    logic      push;
    logic      q_ready;
    logic      q_valid;
    logic      pop;
    logic      raw_valid;
    logic      raw_take;
    nsr_raw_t  raw;

    nsr_front u_front (
        .rx      (rx),
        .q_ready (q_ready),
        .push    (push),
        .item    (front_item)
    );

    nsr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item_in  (front_item),
        .ready    (q_ready),
        .valid    (q_valid),
        .item_out (q_item),
        .pop      (pop)
    );

    nsr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop),
        .raw_valid (raw_valid),
        .raw       (raw),
        .raw_take  (raw_take)
    );

    nsr_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .raw_valid (raw_valid),
        .raw       (raw),
        .raw_take  (raw_take),
        .result    (result)
    );

endmodule

`default_nettype wire
